### hw/rtl/rid_pkg.sv
// Shared widths, control types and helpers for the rounding integer divider.
package rid_pkg;

   localparam int DataWidth = 64;
   localparam int DivStages = DataWidth;

   typedef logic [DataWidth-1:0] word_type;

   // Per-item control flags that travel alongside the data through every stage.
   typedef struct packed {
      logic is_signed;
      logic neg_a;
      logic neg_b;
      logic div_zero;
      logic ovf;
   } ctl_type;

   localparam word_type SignMask = {1'b1, {(DataWidth-1){1'b0}}};

   function automatic word_type negate(input word_type v);
      return (~v) + word_type'(1);
   endfunction

endpackage

### hw/rtl/rid_channel_if.sv
// Valid/ready channel interfaces for the divider request and response.
interface rid_req_if;
   logic               valid;
   logic               ready;
   logic               cmd;
   rid_pkg::word_type  dividend;
   rid_pkg::word_type  divisor;

   modport source (output valid, output cmd, output dividend, output divisor, input ready);
   modport sink   (input valid, input cmd, input dividend, input divisor, output ready);
endinterface

interface rid_rsp_if;
   logic               valid;
   logic               ready;
   rid_pkg::word_type  quotient;
   rid_pkg::word_type  remainder;
   logic               divide_by_zero;
   logic               overflow;

   modport source (output valid, output quotient, output remainder,
                   output divide_by_zero, output overflow, input ready);
   modport sink   (input valid, input quotient, input remainder,
                   input divide_by_zero, input overflow, output ready);
endinterface

### hw/rtl/rounding_integer_divider.sv
// Rounding 64-bit integer divider, fully pipelined with one quotient bit per stage.
// Stages, in order from a request transfer to the response becoming valid:
// one operand stage, 64 restoring-division stages, one sign stage, one output stage.
// Throughput: one transfer per cycle; the whole pipe holds while a response waits.
// Reset (synchronous, active high) clears every stage valid bit; data registers are not reset.
module rounding_integer_divider (
   input  logic           clock,
   input  logic           reset,
   rid_req_if.sink        req_ch,
   rid_rsp_if.source      rsp_ch
);

   localparam int N = rid_pkg::DivStages;

   // The pipe advances whenever the output register is empty or being taken.
   // Every stage moves together, so no item is dropped or duplicated on a stall.
   logic adv;
   assign adv          = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = adv;

   // Operand stage: signs are stripped so the divider core works on magnitudes.
   logic               vld_ff [0:N];
   rid_pkg::word_type  rem_ff [0:N];
   rid_pkg::word_type  aq_ff  [0:N];
   rid_pkg::word_type  mb_ff  [0:N];
   rid_pkg::ctl_type   ctl_ff [0:N];

   rid_pkg::word_type  rem_in [1:N];
   rid_pkg::word_type  aq_in  [1:N];

   rid_pkg::ctl_type   ctl0_in;
   rid_pkg::word_type  ma_in;
   rid_pkg::word_type  mb_in;

   always_comb begin
      ctl0_in.is_signed = req_ch.cmd;
      ctl0_in.neg_a     = req_ch.cmd && req_ch.dividend[rid_pkg::DataWidth-1];
      ctl0_in.neg_b     = req_ch.cmd && req_ch.divisor[rid_pkg::DataWidth-1];
      ctl0_in.div_zero  = (req_ch.divisor == '0);
      ctl0_in.ovf       = req_ch.cmd && (req_ch.dividend == rid_pkg::SignMask)
                          && (req_ch.divisor == '1);
      ma_in = ctl0_in.neg_a ? rid_pkg::negate(req_ch.dividend) : req_ch.dividend;
      mb_in = ctl0_in.neg_b ? rid_pkg::negate(req_ch.divisor) : req_ch.divisor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= '0;
         aq_ff[0]  <= ma_in;
         mb_ff[0]  <= mb_in;
         ctl_ff[0] <= ctl0_in;
      end
   end

   // Restoring division: each stage shifts in the next dividend bit, tries one
   // subtraction of the divisor magnitude and shifts the quotient bit into aq.
   // After the last stage aq holds the quotient and rem the remainder.
   for (genvar k = 0; k < N; k++) begin : g_div
      logic [rid_pkg::DataWidth:0]   shifted;
      logic [rid_pkg::DataWidth+1:0] diff;
      logic                          borrow;

      assign shifted = {rem_ff[k], aq_ff[k][rid_pkg::DataWidth-1]};
      assign diff    = {1'b0, shifted} - {2'b00, mb_ff[k]};
      assign borrow  = diff[rid_pkg::DataWidth+1];

      assign rem_in[k+1] = borrow ? shifted[rid_pkg::DataWidth-1:0]
                                  : diff[rid_pkg::DataWidth-1:0];
      assign aq_in[k+1]  = {aq_ff[k][rid_pkg::DataWidth-2:0], ~borrow};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k+1] <= rem_in[k+1];
            aq_ff[k+1]  <= aq_in[k+1];
            mb_ff[k+1]  <= mb_ff[k];
            ctl_ff[k+1] <= ctl_ff[k];
         end
      end
   end

   // Sign stage: restore the signs of quotient and remainder and form the
   // signed half of the divisor, which is the rounding threshold.
   logic               sgn_vld_ff;
   rid_pkg::word_type  sgn_q_ff,    sgn_q_in;
   rid_pkg::word_type  sgn_r_ff,    sgn_r_in;
   rid_pkg::word_type  sgn_half_ff, sgn_half_in;
   rid_pkg::ctl_type   sgn_ctl_ff;
   rid_pkg::word_type  half_mag;

   always_comb begin
      half_mag    = mb_ff[N] >> 1;
      sgn_q_in    = (ctl_ff[N].neg_a != ctl_ff[N].neg_b) ? rid_pkg::negate(aq_ff[N])
                                                         : aq_ff[N];
      sgn_r_in    = ctl_ff[N].neg_a ? rid_pkg::negate(rem_ff[N]) : rem_ff[N];
      sgn_half_in = ctl_ff[N].neg_b ? rid_pkg::negate(half_mag) : half_mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sgn_vld_ff <= 1'b0;
      end else if (adv) begin
         sgn_vld_ff <= vld_ff[N];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sgn_q_ff    <= sgn_q_in;
         sgn_r_ff    <= sgn_r_in;
         sgn_half_ff <= sgn_half_in;
         sgn_ctl_ff  <= ctl_ff[N];
      end
   end

   // Output stage: round up when the remainder exceeds the threshold. Flipping
   // the sign bits turns the unsigned compare into a signed one in signed mode.
   // Divide-by-zero and signed overflow force both data fields to zero.
   logic               out_vld_ff;
   rid_pkg::word_type  quo_ff, quo_in;
   rid_pkg::word_type  rmd_ff, rmd_in;
   logic               dbz_ff;
   logic               ovf_ff;
   rid_pkg::word_type  flip;
   logic               round_up;
   logic               kill;

   always_comb begin
      flip     = sgn_ctl_ff.is_signed ? rid_pkg::SignMask : '0;
      round_up = (sgn_r_ff ^ flip) > (sgn_half_ff ^ flip);
      kill     = sgn_ctl_ff.div_zero || sgn_ctl_ff.ovf;
      quo_in   = kill ? '0 : (round_up ? sgn_q_ff + rid_pkg::word_type'(1) : sgn_q_ff);
      rmd_in   = kill ? '0 : sgn_r_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= sgn_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         quo_ff <= quo_in;
         rmd_ff <= rmd_in;
         dbz_ff <= sgn_ctl_ff.div_zero;
         ovf_ff <= sgn_ctl_ff.ovf && !sgn_ctl_ff.div_zero;
      end
   end

   assign rsp_ch.valid          = out_vld_ff;
   assign rsp_ch.quotient       = quo_ff;
   assign rsp_ch.remainder      = rmd_ff;
   assign rsp_ch.divide_by_zero = dbz_ff;
   assign rsp_ch.overflow       = ovf_ff;

endmodule
